// ----- design/xcs_pkg.sv -----
// ----------------------------------------------------------------------------
// XMODEM checksum sender package
// Shared types, symbols and sizes for the sender core and its controller.
// ----------------------------------------------------------------------------
package xcs_pkg;

  localparam int BLOCK_BYTES = 128;
  localparam int ADDR_W      = $clog2(BLOCK_BYTES);
  localparam int DATA_OFFSET = 3;
  localparam int FRAME_LAST  = BLOCK_BYTES + DATA_OFFSET;

  localparam logic [7:0] SYM_SOH = 8'h01;
  localparam logic [7:0] SYM_EOT = 8'h04;
  localparam logic [7:0] SYM_ACK = 8'h06;
  localparam logic [7:0] SYM_NAK = 8'h15;
  localparam logic [7:0] SYM_CAN = 8'h18;
  localparam logic [7:0] SYM_PAD = 8'hFF;

  localparam logic [7:0] RETRY_LIMIT_RST = 8'd100;
  localparam logic [7:0] RETRY_MAX       = 8'd255;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_RX      = 2'd1,
    OP_TIMEOUT = 2'd2,
    OP_TX_SLOT = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    PH_WAIT   = 3'd0,
    PH_SEND   = 3'd1,
    PH_REPLY  = 3'd2,
    PH_NEED   = 3'd3,
    PH_DONE   = 3'd4,
    PH_FAIL   = 3'd5,
    PH_CANCEL = 3'd6,
    PH_EOT    = 3'd7
  } phase_t;

  typedef struct packed {
    logic             tx_valid;
    logic             use_mem;
    logic             add_sum;
    logic             take_sum;
    logic             clear_sum;
    logic [7:0]       tx_byte;
    logic [2:0]       status;
    logic [7:0]       block_count;
    logic [7:0]       retries;
  } item_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } mem_req_t;

endpackage

// ----- design/xcs_if.sv -----
// ----------------------------------------------------------------------------
// XMODEM checksum sender channels
// Valid/ready channels for requests into the core and results out of it.
// ----------------------------------------------------------------------------
interface xcs_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] data_byte;
  logic       end_of_file;

  modport source (output valid, operation, data_byte, end_of_file, input ready);
  modport sink   (input valid, operation, data_byte, end_of_file, output ready);
endinterface

interface xcs_out_if;
  logic       valid;
  logic       ready;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic [2:0] status;
  logic [7:0] block_count;
  logic [7:0] retries;

  modport source (output valid, tx_valid, tx_byte, status, block_count, retries,
                  input ready);
  modport sink   (input valid, tx_valid, tx_byte, status, block_count, retries,
                  output ready);
endinterface

// ----- design/xcs_ctrl.sv -----
// ----------------------------------------------------------------------------
// XMODEM checksum sender controller
// Protocol state, frame pointer and retry counting; issues store accesses.
// ----------------------------------------------------------------------------
module xcs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [1:0]        operation,
  input  logic [7:0]        data_byte,
  input  logic              end_of_file,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata,
  output xcs_pkg::item_t    item,
  output xcs_pkg::mem_req_t mem_req
);

  xcs_pkg::phase_t phase_r, phase_nxt;
  logic [7:0] fill_r, fill_nxt;
  logic       file_r, file_nxt;
  logic [7:0] fp_r, fp_nxt;
  logic [7:0] block_r, block_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic [7:0] limit_r;

  logic       ready_now;
  logic       ready_after;
  logic [7:0] cnt_inc;
  logic       do_start;
  logic [7:0] idx;

  assign ready_now   = (fill_r >= 8'(xcs_pkg::BLOCK_BYTES)) || file_r;
  assign ready_after = ((fill_r + 8'd1) >= 8'(xcs_pkg::BLOCK_BYTES)) || file_r || end_of_file;
  assign cnt_inc     = (cnt_r == xcs_pkg::RETRY_MAX) ? cnt_r : cnt_r + 8'd1;
  assign idx         = fp_r - 8'(xcs_pkg::DATA_OFFSET);

  // Next state.
  always_comb begin
    phase_nxt = phase_r;
    fill_nxt  = fill_r;
    file_nxt  = file_r;
    fp_nxt    = fp_r;
    block_nxt = block_r;
    cnt_nxt   = cnt_r;
    do_start  = 1'b0;
    case (xcs_pkg::op_t'(operation))
      xcs_pkg::OP_LOAD: begin
        if ((phase_r == xcs_pkg::PH_WAIT || phase_r == xcs_pkg::PH_NEED) && !ready_now) begin
          fill_nxt = fill_r + 8'd1;
          if (end_of_file) begin
            file_nxt = 1'b1;
          end
          if (phase_r == xcs_pkg::PH_NEED && ready_after) begin
            do_start = 1'b1;
          end
        end
      end
      xcs_pkg::OP_RX: begin
        if (phase_r == xcs_pkg::PH_WAIT) begin
          if (data_byte == xcs_pkg::SYM_NAK) begin
            cnt_nxt = 8'd0;
            if (ready_now) begin
              do_start = 1'b1;
            end else begin
              phase_nxt = xcs_pkg::PH_NEED;
            end
          end else begin
            cnt_nxt = cnt_inc;
            if (cnt_inc >= limit_r) begin
              phase_nxt = xcs_pkg::PH_FAIL;
            end
          end
        end else if (phase_r == xcs_pkg::PH_REPLY) begin
          if (data_byte == xcs_pkg::SYM_ACK) begin
            cnt_nxt   = 8'd0;
            block_nxt = block_r + 8'd1;
            if (file_r) begin
              phase_nxt = xcs_pkg::PH_EOT;
            end else begin
              fill_nxt  = 8'd0;
              phase_nxt = xcs_pkg::PH_NEED;
            end
          end else if (data_byte == xcs_pkg::SYM_CAN) begin
            phase_nxt = xcs_pkg::PH_CANCEL;
          end else begin
            cnt_nxt = cnt_inc;
            if (cnt_inc >= limit_r) begin
              phase_nxt = xcs_pkg::PH_FAIL;
            end else if (data_byte == xcs_pkg::SYM_NAK) begin
              do_start = 1'b1;
            end
          end
        end
      end
      xcs_pkg::OP_TIMEOUT: begin
        if (phase_r == xcs_pkg::PH_WAIT || phase_r == xcs_pkg::PH_REPLY) begin
          cnt_nxt = cnt_inc;
          if (cnt_inc >= limit_r) begin
            phase_nxt = xcs_pkg::PH_FAIL;
          end
        end
      end
      xcs_pkg::OP_TX_SLOT: begin
        if (phase_r == xcs_pkg::PH_SEND) begin
          if (fp_r >= 8'(xcs_pkg::FRAME_LAST)) begin
            fp_nxt    = 8'd0;
            phase_nxt = xcs_pkg::PH_REPLY;
          end else begin
            fp_nxt = fp_r + 8'd1;
          end
        end else if (phase_r == xcs_pkg::PH_EOT) begin
          phase_nxt = xcs_pkg::PH_DONE;
        end
      end
      default: begin
      end
    endcase
    if (do_start) begin
      fp_nxt    = 8'd0;
      phase_nxt = xcs_pkg::PH_SEND;
    end
  end

  // Result descriptor and store accesses.
  always_comb begin
    item             = '0;
    mem_req          = '0;
    mem_req.wr_addr  = fill_r[xcs_pkg::ADDR_W-1:0];
    mem_req.wr_data  = data_byte;
    mem_req.rd_addr  = idx[xcs_pkg::ADDR_W-1:0];
    item.clear_sum   = do_start;
    item.status      = (phase_nxt == xcs_pkg::PH_EOT) ? xcs_pkg::PH_SEND : phase_nxt;
    item.block_count = block_nxt;
    item.retries     = cnt_nxt;
    case (xcs_pkg::op_t'(operation))
      xcs_pkg::OP_LOAD: begin
        mem_req.wr_en = accept && (fill_nxt != fill_r);
      end
      xcs_pkg::OP_TX_SLOT: begin
        if (phase_r == xcs_pkg::PH_SEND) begin
          item.tx_valid = 1'b1;
          if (fp_r == 8'd0) begin
            item.tx_byte = xcs_pkg::SYM_SOH;
          end else if (fp_r == 8'd1) begin
            item.tx_byte = block_r;
          end else if (fp_r == 8'd2) begin
            item.tx_byte = ~block_r;
          end else if (fp_r < 8'(xcs_pkg::FRAME_LAST)) begin
            item.add_sum = 1'b1;
            if (idx < fill_r) begin
              item.use_mem  = 1'b1;
              mem_req.rd_en = accept;
            end else begin
              item.tx_byte = xcs_pkg::SYM_PAD;
            end
          end else begin
            item.take_sum = 1'b1;
          end
        end else if (phase_r == xcs_pkg::PH_EOT) begin
          item.tx_valid = 1'b1;
          item.tx_byte  = xcs_pkg::SYM_EOT;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= xcs_pkg::PH_WAIT;
      fill_r  <= 8'd0;
      file_r  <= 1'b0;
      fp_r    <= 8'd0;
      block_r <= 8'd1;
      cnt_r   <= 8'd0;
      limit_r <= xcs_pkg::RETRY_LIMIT_RST;
    end else begin
      if (accept) begin
        phase_r <= phase_nxt;
        fill_r  <= fill_nxt;
        file_r  <= file_nxt;
        fp_r    <= fp_nxt;
        block_r <= block_nxt;
        cnt_r   <= cnt_nxt;
      end
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
    end
  end

endmodule

// ----- design/xmodem_checksum_sender_core.sv -----
// ----------------------------------------------------------------------------
// XMODEM checksum sender core
// Frames loaded firmware blocks into XMODEM packets with an 8-bit sum.
// ----------------------------------------------------------------------------
//   Channel   Direction  Carries
//   in_chan   in         operation, data_byte, end_of_file
//   out_chan  out        tx_valid, tx_byte, status, block_count, retries
//   cfg_*     in         retry_limit write
//
// One request is accepted per cycle unless a stall holds it. On acceptance it
// enters the request stage, where the registered read of the block store
// completes; when that stage advances, its result moves into the output
// register, from which the result is offered.
// A stalled result holds the request stage, which then stops acceptance.
// Reset is synchronous and needs no clearing pass; the store is never read
// before it is written.
module xmodem_checksum_sender_core (
  input  logic              clk,
  input  logic              rst_n,
  xcs_in_if.sink            in_chan,
  xcs_out_if.source         out_chan,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata
);

  logic [7:0] mem [xcs_pkg::BLOCK_BYTES];
  logic [7:0] rd_data_r;

  xcs_pkg::item_t    item;
  xcs_pkg::mem_req_t mem_req;
  xcs_pkg::item_t    s1_r;
  logic              s1_valid_r;
  logic              s1_adv;
  logic              accept;
  logic [7:0]        sum_r, sum_nxt;
  logic [7:0]        s1_byte;

  logic       out_valid_r;
  logic       out_tx_valid_r;
  logic [7:0] out_tx_byte_r;
  logic [2:0] out_status_r;
  logic [7:0] out_block_r;
  logic [7:0] out_retries_r;

  assign s1_adv        = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s1_adv;
  assign accept        = in_chan.valid && in_chan.ready;

  xcs_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .operation   (in_chan.operation),
    .data_byte   (in_chan.data_byte),
    .end_of_file (in_chan.end_of_file),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .item        (item),
    .mem_req     (mem_req)
  );

  always_ff @(posedge clk) begin
    if (mem_req.wr_en) begin
      mem[mem_req.wr_addr] <= mem_req.wr_data;
    end
    if (mem_req.rd_en) begin
      rd_data_r <= mem[mem_req.rd_addr];
    end
  end

  always_comb begin
    if (s1_r.use_mem) begin
      s1_byte = rd_data_r;
    end else if (s1_r.take_sum) begin
      s1_byte = sum_r;
    end else begin
      s1_byte = s1_r.tx_byte;
    end
    sum_nxt = sum_r;
    if (s1_adv) begin
      if (s1_r.clear_sum) begin
        sum_nxt = 8'd0;
      end else if (s1_r.add_sum) begin
        sum_nxt = sum_r + s1_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      sum_r       <= 8'd0;
    end else begin
      sum_r <= sum_nxt;
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= item;
    end
    if (s1_adv) begin
      out_tx_valid_r <= s1_r.tx_valid;
      out_tx_byte_r  <= s1_byte;
      out_status_r   <= s1_r.status;
      out_block_r    <= s1_r.block_count;
      out_retries_r  <= s1_r.retries;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.tx_valid    = out_tx_valid_r;
  assign out_chan.tx_byte     = out_tx_byte_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.block_count = out_block_r;
  assign out_chan.retries     = out_retries_r;

endmodule
